FILE: src/tqs_pkg.sv
`timescale 1ns / 1ps
package tqs_pkg;

	localparam int unsigned IdW      = 16;
	localparam int unsigned IntvW    = 32;
	localparam int unsigned RepW     = 16;
	localparam int unsigned MaxFires = 32;
	localparam int unsigned FireCntW = 6;
	localparam logic [IntvW-1:0] MinPeriodRst = 32'd100;

	typedef enum logic [2:0] {
		REQ_TICK    = 3'd0,
		REQ_ONESHOT = 3'd1,
		REQ_TICKER  = 3'd2,
		REQ_CANCEL  = 3'd3,
		REQ_QUERY   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRD,
		ST_TEV,
		ST_TFIN,
		ST_FRD,
		ST_FEV,
		ST_SCHED,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic           status;
		logic [IdW-1:0] timer_id;
		logic           fired;
		logic           is_cancelled;
		logic           last;
	} res_t;

endpackage

FILE: src/tqs_slot_mem.sv
`timescale 1ns / 1ps
module tqs_slot_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 112
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/tqs_out_reg.sv
`timescale 1ns / 1ps
module tqs_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tqs_pkg::res_t push_res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output tqs_pkg::res_t res
);
	import tqs_pkg::*;

	logic  valid_q;
	res_t  res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_res;
		end
	end

endmodule

FILE: src/timer_queue_scheduler.sv
`timescale 1ns / 1ps
// Timer table. One request at a time enters on in_valid/in_ready with req_type and its
// operands; results leave on out_valid/out_ready, the final one of a request marked by last.
// Configuration: cfg_valid/cfg_ready/cfg_data writes min_period; write it only while idle.
// Timer entries sit in a single-port-read slot memory with a registered read port; each
// entry visit is a read state followed by an evaluate state.
// Schedule: the request passes through a write state and then an emit state.  Cancel and query
// search the table in order and stop at the first hit; a miss visits every live entry.
// Tick walks every live entry, writing survivors back compacted.
// A request is taken only once the previous one has handed over its last result.
// A one-deep output register decouples the receiver; when it stalls, the walk pauses on the
// next due timer and resumes as the register drains.
// Reset empties the table (live count zero), sets the next id to 1 and min_period to 100.
// Memory contents need no clearing.
module timer_queue_scheduler #(
	parameter int unsigned TIMERS    = 32,
	parameter int unsigned TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            req_type,
	input  logic [TIME_BITS-1:0]  now_time,
	input  logic [31:0]           delay_time,
	input  logic [15:0]           repeat_count,
	input  logic [15:0]           target_id,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [31:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status,
	output logic [15:0]           timer_id,
	output logic                  fired,
	output logic                  is_cancelled,
	output logic                  last
);
	import tqs_pkg::*;

	localparam int unsigned IW = $clog2(TIMERS);
	localparam int unsigned CW = $clog2(TIMERS + 1);
	localparam int unsigned EW = IdW + TIME_BITS + IntvW + RepW;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [IntvW-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS + 1 - IntvW){1'b0}}, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	state_t               state_q, state_d;
	req_t                 req_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IntvW-1:0]     delay_q;
	logic [RepW-1:0]      reps_q;
	logic [IdW-1:0]       tgt_q;
	logic [CW-1:0]        idx_q, wr_q, live_q;
	logic [FireCntW-1:0]  nfire_q;
	logic                 pend_v_q;
	logic [IdW-1:0]       pend_id_q;
	logic [IdW-1:0]       next_id_q;
	logic [IntvW-1:0]     minp_q;
	logic [TIMERS-1:0]    cancel_q;
	res_t                 resp_q;

	logic                 mem_re, mem_we;
	logic [IW-1:0]        mem_raddr, mem_waddr;
	logic [EW-1:0]        mem_rdata, mem_wdata;

	logic                 out_free, push;
	res_t                 push_res, out_res;

	// entry fields as read
	logic [IdW-1:0]       e_id;
	logic [TIME_BITS-1:0] e_dl;
	logic [IntvW-1:0]     e_iv;
	logic [RepW-1:0]      e_rm;
	assign {e_id, e_dl, e_iv, e_rm} = mem_rdata;

	logic                 e_cancel, due, stall, kill;
	logic [TIME_BITS-1:0] new_dl;
	logic [RepW-1:0]      new_rm;
	logic                 full;
	logic [IntvW-1:0]     sched_iv;
	logic [IdW-1:0]       id_inc;
	logic [CW-1:0]        idx_inc;

	assign e_cancel = cancel_q[idx_q[IW-1:0]];
	assign due      = !e_cancel && (e_dl <= now_q) && (nfire_q < FireCntW'(MaxFires));
	assign stall    = due && pend_v_q && !out_free;
	assign kill     = e_cancel || (due && ((e_iv == '0) || (e_rm == RepW'(1))));
	assign new_dl   = (due && e_iv != '0) ? sat_add(e_dl, e_iv) : e_dl;
	assign new_rm   = (due && e_iv != '0 && e_rm != '0) ? e_rm - RepW'(1) : e_rm;
	assign full     = (live_q >= CW'(TIMERS));
	assign id_inc   = next_id_q + IdW'(1);
	assign idx_inc  = idx_q + CW'(1);

	always_comb begin
		sched_iv = '0;
		if (req_q == REQ_TICKER) begin
			sched_iv = (delay_q < minp_q) ? minp_q : delay_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = wr_q[IW-1:0];
		mem_wdata = {e_id, new_dl, e_iv, new_rm};
		push      = 1'b0;
		push_res  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_type) inside
						REQ_TICK:                 state_d = ST_TRD;
						REQ_ONESHOT, REQ_TICKER:  state_d = ST_SCHED;
						REQ_CANCEL, REQ_QUERY:    state_d = ST_FRD;
						default:                  state_d = ST_EMIT;
					endcase
				end
			end
			ST_TRD: begin
				if (idx_q == live_q) begin
					state_d = ST_TFIN;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_TEV;
				end
			end
			ST_TEV: begin
				if (!stall) begin
					mem_we = !kill;
					if (due && pend_v_q) begin
						push              = 1'b1;
						push_res.timer_id = pend_id_q;
						push_res.fired    = 1'b1;
					end
					state_d = ST_TRD;
				end
			end
			ST_TFIN: begin
				if (out_free) begin
					push          = 1'b1;
					push_res.last = 1'b1;
					if (pend_v_q) begin
						push_res.timer_id = pend_id_q;
						push_res.fired    = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_FRD: begin
				if (idx_q == live_q) begin
					state_d = ST_EMIT;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_FEV;
				end
			end
			ST_FEV: begin
				state_d = (e_id == tgt_q) ? ST_EMIT : ST_FRD;
			end
			ST_SCHED: begin
				if (!full) begin
					mem_we    = 1'b1;
					mem_waddr = live_q[IW-1:0];
					mem_wdata = {next_id_q, sat_add(now_q, (req_q == REQ_TICKER) ? sched_iv
						: delay_q), sched_iv, (req_q == REQ_TICKER) ? reps_q : RepW'(1)};
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					push     = 1'b1;
					push_res = resp_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			live_q    <= '0;
			next_id_q <= IdW'(1);
			minp_q    <= MinPeriodRst;
			cancel_q  <= '0;
			pend_v_q  <= 1'b0;
			nfire_q   <= '0;
			idx_q     <= '0;
			wr_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				minp_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q    <= '0;
					wr_q     <= '0;
					nfire_q  <= '0;
					pend_v_q <= 1'b0;
				end
				ST_TEV: begin
					if (!stall) begin
						idx_q <= idx_inc;
						if (!kill) begin
							cancel_q[wr_q[IW-1:0]] <= 1'b0;
							wr_q <= wr_q + CW'(1);
						end
						if (due) begin
							pend_v_q <= 1'b1;
							nfire_q  <= nfire_q + FireCntW'(1);
						end
					end
				end
				ST_TFIN: begin
					live_q <= wr_q;
				end
				ST_FEV: begin
					idx_q <= idx_inc;
					if (e_id == tgt_q && req_q == REQ_CANCEL) begin
						cancel_q[idx_q[IW-1:0]] <= 1'b1;
					end
				end
				ST_SCHED: begin
					if (!full) begin
						cancel_q[live_q[IW-1:0]] <= 1'b0;
						live_q    <= live_q + CW'(1);
						next_id_q <= (id_inc == '0) ? IdW'(1) : id_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q   <= req_t'(req_type);
					now_q   <= now_time;
					delay_q <= delay_time;
					reps_q  <= repeat_count;
					tgt_q   <= target_id;
					resp_q  <= '{status: 1'b0, timer_id: '0, fired: 1'b0,
						is_cancelled: 1'b0, last: 1'b1};
				end
			end
			ST_TEV: begin
				if (!stall && due) begin
					pend_id_q <= e_id;
				end
			end
			ST_FRD: begin
				if (idx_q == live_q) begin
					resp_q.timer_id     <= tgt_q;
					resp_q.is_cancelled <= (req_q == REQ_QUERY);
				end
			end
			ST_FEV: begin
				if (e_id == tgt_q) begin
					resp_q.timer_id     <= tgt_q;
					resp_q.is_cancelled <= (req_q == REQ_QUERY) && e_cancel;
				end
			end
			ST_SCHED: begin
				resp_q.status   <= full;
				resp_q.timer_id <= full ? '0 : next_id_q;
			end
			default: ;
		endcase
	end

	tqs_slot_mem #(
		.DEPTH (TIMERS),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	tqs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (out_res)
	);

	assign status       = out_res.status;
	assign timer_id     = out_res.timer_id;
	assign fired        = out_res.fired;
	assign is_cancelled = out_res.is_cancelled;
	assign last         = out_res.last;

endmodule
